// ===== sv/cmlc_pkg.sv =====
// cmlc_pkg: sizes, divider constants and controller/datapath interface types
// for the current monitor with weighted moving average and coupling detect.
// No dependencies.
package cmlc_pkg;

  localparam int HIST_LEN = 16;
  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 15;

  localparam int SLOT_W = $clog2(HIST_LEN);
  localparam int SEEN_W = $clog2(HIST_LEN + 2);
  localparam int WGT_W  = $clog2(HIST_LEN + 1);

  // sum of weights 1..N
  localparam int DIV_C = (HIST_LEN * (HIST_LEN + 1)) / 2;
  localparam int ACC_W = SAMPLE_W + $clog2(DIV_C) + 1;
  // quotient magnitude reaches 32768
  localparam int Q_W   = SAMPLE_W + 1;

  // floor(2^32 / DIV_C), quotient estimate is low by at most one
  localparam int RECIP_SH = 32;
  localparam longint unsigned RECIP_L = (64'd1 << RECIP_SH) / DIV_C;
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_L[RECIP_SH-1:0];
  localparam int PROD_W = ACC_W + RECIP_SH;

  typedef struct packed {
    logic load;
    logic mac;
    logic take_abs;
    logic mul;
    logic fix;
    logic publish;
  } cmlc_cmd_t;

  typedef struct packed {
    logic full;
    logic mac_last;
    logic out_busy;
  } cmlc_status_t;

endpackage

// ===== sv/cmlc_ctrl.sv =====
// cmlc_ctrl: sequencer for one transaction: accept, weighted sum, divide,
// publish. Depends on cmlc_pkg.
module cmlc_ctrl import cmlc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  cmlc_status_t status,
  output cmlc_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MAC     = 3'd1;
  localparam logic [2:0] ST_ABS     = 3'd2;
  localparam logic [2:0] ST_MUL     = 3'd3;
  localparam logic [2:0] ST_FIX     = 3'd4;
  localparam logic [2:0] ST_PUBLISH = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          // no average until the ring is full
          state_nxt = status.full ? ST_MAC : ST_PUBLISH;
        end
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        if (status.mac_last) state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd.take_abs = 1'b1;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== sv/cmlc_datapath.sv =====
// cmlc_datapath: sample ring, max/min tracking, weighted accumulate,
// reciprocal divide, coupling flags and output register. Depends on cmlc_pkg.
module cmlc_datapath import cmlc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmlc_cmd_t                  cmd,
  output cmlc_status_t               status,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       cfg_wr_en,
  input  logic [THR_W-1:0]           cfg_wr_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_average,
  output logic signed [SAMPLE_W-1:0] out_max,
  output logic signed [SAMPLE_W-1:0] out_min,
  output logic                       out_coupled,
  output logic                       out_lost,
  output logic                       out_gained
);

  logic signed [SAMPLE_W-1:0] hist_mem [HIST_LEN];

  logic [SLOT_W-1:0]          slot_r;
  logic [SLOT_W-1:0]          pos_r;
  logic [SEEN_W-1:0]          seen_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic                       coupled_r;
  logic [THR_W-1:0]           thr_r;

  logic [WGT_W-1:0]           issue_w_r;
  logic [WGT_W-1:0]           rd_w_r;
  logic                       rd_vld_r;
  logic signed [SAMPLE_W-1:0] rd_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       neg_r;
  logic [ACC_W-1:0]           mag_r;
  logic [PROD_W-1:0]          prod_r;
  logic [Q_W-1:0]             q_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_avg_r;
  logic signed [SAMPLE_W-1:0] out_max_r;
  logic signed [SAMPLE_W-1:0] out_min_r;
  logic                       out_coupled_r;
  logic                       out_lost_r;
  logic                       out_gained_r;

  logic signed [SAMPLE_W+WGT_W:0] term;
  logic [ACC_W-1:0]               q0;
  logic [ACC_W-1:0]               rem;
  logic [Q_W-1:0]                 q_fix;
  logic [Q_W-1:0]                 avg_wide;
  logic                           coupled_nxt;

  assign status.full     = (seen_r == SEEN_W'(HIST_LEN + 1));
  assign status.mac_last = (issue_w_r == '0) && rd_vld_r;
  assign status.out_busy = out_valid_r && out_stall;

  assign term = rd_r * $signed({1'b0, rd_w_r});

  // quotient estimate and one-step correction
  assign q0    = prod_r[PROD_W-1:RECIP_SH];
  assign rem   = mag_r - ACC_W'(q0 * ACC_W'(DIV_C));
  assign q_fix = (rem >= ACC_W'(DIV_C)) ? Q_W'(q0 + ACC_W'(1)) : Q_W'(q0);

  assign avg_wide    = neg_r ? (~q_r + Q_W'(1)) : q_r;
  assign coupled_nxt = (q_r > Q_W'(thr_r));

  // ring storage
  always_ff @(posedge clk) begin
    if (cmd.load) hist_mem[slot_r] <= in_sample;
    if (cmd.mac && (issue_w_r != '0)) rd_r <= hist_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      seen_r      <= '0;
      max_r       <= '0;
      min_r       <= SAMPLE_W'(32767);
      coupled_r   <= 1'b0;
      thr_r       <= '0;
      issue_w_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;

      if (cmd.load) begin
        slot_r    <= (slot_r == SLOT_W'(HIST_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);
        if (seen_r <= SEEN_W'(HIST_LEN)) seen_r <= seen_r + SEEN_W'(1);
        if (in_sample > max_r) max_r <= in_sample;
        if (in_sample < min_r) min_r <= in_sample;
        issue_w_r <= WGT_W'(HIST_LEN);
        rd_vld_r  <= 1'b0;
      end

      if (cmd.mac) begin
        if (issue_w_r != '0) begin
          issue_w_r <= issue_w_r - WGT_W'(1);
          rd_vld_r  <= 1'b1;
        end else begin
          rd_vld_r  <= 1'b0;
        end
      end

      if (cmd.publish) begin
        out_valid_r <= 1'b1;
        coupled_r   <= coupled_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r <= slot_r;
      acc_r <= '0;
      neg_r <= 1'b0;
      q_r   <= '0;
    end
    if (cmd.mac) begin
      if (issue_w_r != '0) begin
        rd_w_r <= issue_w_r;
        pos_r  <= (pos_r == '0) ? SLOT_W'(HIST_LEN - 1) : pos_r - SLOT_W'(1);
      end
      if (rd_vld_r) acc_r <= acc_r + ACC_W'(term);
    end
    if (cmd.take_abs) begin
      neg_r <= acc_r[ACC_W-1];
      mag_r <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    end
    if (cmd.mul) prod_r <= PROD_W'(mag_r) * PROD_W'(RECIP);
    if (cmd.fix) q_r <= q_fix;
    if (cmd.publish) begin
      out_avg_r     <= avg_wide[SAMPLE_W-1:0];
      out_max_r     <= max_r;
      out_min_r     <= min_r;
      out_coupled_r <= coupled_nxt;
      out_lost_r    <= coupled_r && !coupled_nxt;
      out_gained_r  <= !coupled_r && coupled_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_avg_r;
  assign out_max     = out_max_r;
  assign out_min     = out_min_r;
  assign out_coupled = out_coupled_r;
  assign out_lost    = out_lost_r;
  assign out_gained  = out_gained_r;

endmodule

// ===== sv/current_monitor_lwma_coupling.sv =====
// current_monitor_lwma_coupling: top level, controller plus datapath.
// Depends on cmlc_pkg, cmlc_ctrl, cmlc_datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid / in_stall    | in_sample_ma
//  result   | out_valid / out_stall  | out_average_ma, out_max_ma, out_min_ma,
//           |                        | out_is_coupled, out_lost_coupling,
//           |                        | out_gained_coupling
//  config   | cfg_wr_en              | cfg_wr_data (coupling threshold)
//
// a filling ring sends a transaction from accept straight to publish; once
// full, the weighted sum reads the ring one entry per cycle through a single
// multiply-accumulate, then absolute value, reciprocal multiply, correction
// and publish steps. reset is synchronous; no clearing pass is needed.
// a new sample is taken while the previous result still waits in the output
// register; a stalled result holds the sequencer only at its publish step.
module current_monitor_lwma_coupling import cmlc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_ma,
  input  logic                       cfg_wr_en,
  input  logic [THR_W-1:0]           cfg_wr_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_average_ma,
  output logic signed [SAMPLE_W-1:0] out_max_ma,
  output logic signed [SAMPLE_W-1:0] out_min_ma,
  output logic                       out_is_coupled,
  output logic                       out_lost_coupling,
  output logic                       out_gained_coupling
);

  cmlc_cmd_t    cmd;
  cmlc_status_t status;

  cmlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cmlc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_sample   (in_sample_ma),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_average (out_average_ma),
    .out_max     (out_max_ma),
    .out_min     (out_min_ma),
    .out_coupled (out_is_coupled),
    .out_lost    (out_lost_coupling),
    .out_gained  (out_gained_coupling)
  );

endmodule

// ===== tb/sv/tb_current_monitor_lwma_coupling.sv =====
`timescale 1ns / 100ps
// tb_current_monitor_lwma_coupling: self-checking bench for the current monitor,
// with its own weighted-average and coupling predictor in a small scoreboard class.
// Depends on cmlc_pkg and current_monitor_lwma_coupling.
module tb_current_monitor_lwma_coupling;
  import cmlc_pkg::*;

  localparam longint WEIGHT_SUM = (HIST_LEN * (HIST_LEN + 1)) / 2;

  typedef struct {
    logic signed [SAMPLE_W-1:0] average;
    logic signed [SAMPLE_W-1:0] peak;
    logic signed [SAMPLE_W-1:0] trough;
    logic                       coupled;
    logic                       lost;
    logic                       gained;
  } reading_t;

  class current_monitor_scoreboard;
    shortint          ring [HIST_LEN];
    int               slot;
    int               seen;
    shortint          peak;
    shortint          trough;
    bit               coupled;
    bit [THR_W-1:0]   threshold;
    reading_t         pending_readings [$];
    int               errors;
    int               checked;
    int               gained_seen;
    int               lost_seen;

    function new();
      foreach (ring[i]) ring[i] = 0;
      slot = 0;
      seen = 0;
      peak = 0;
      trough = 32767;
      coupled = 1'b0;
      threshold = '0;
      errors = 0;
      checked = 0;
      gained_seen = 0;
      lost_seen = 0;
    endfunction

    // predict the reading for one accepted sample
    function void take_sample(shortint s);
      longint   acc;
      int       pos;
      int       avg;
      int       mag;
      bit       was;
      reading_t r;
      was = coupled;
      ring[slot] = s;
      if (s > peak) peak = s;
      if (s < trough) trough = s;
      avg = 0;
      if (seen > HIST_LEN) begin
        acc = 0;
        pos = slot;
        for (int w = HIST_LEN; w >= 1; w--) begin
          acc += longint'(ring[pos]) * w;
          pos = (pos == 0) ? HIST_LEN - 1 : pos - 1;
        end
        avg = int'(acc / WEIGHT_SUM);
      end
      if (seen <= HIST_LEN) seen++;
      slot = (slot + 1) % HIST_LEN;
      mag = (avg < 0) ? -avg : avg;
      coupled = (mag > int'(threshold));
      r.average = avg[SAMPLE_W-1:0];
      r.peak    = peak;
      r.trough  = trough;
      r.coupled = coupled;
      r.lost    = was && !coupled;
      r.gained  = !was && coupled;
      pending_readings.push_back(r);
    endfunction

    function void check_reading(input logic signed [SAMPLE_W-1:0] average, peak_a, trough_a,
                                input logic coupled_a, lost_a, gained_a);
      reading_t e;
      if (pending_readings.size() == 0) begin
        errors++;
        $error("result with no transaction pending: average_ma %0d", average);
        return;
      end
      e = pending_readings.pop_front();
      checked++;
      if (average !== e.average) begin
        errors++;
        $error("average_ma: expected %0d, actual %0d", e.average, average);
      end
      if (peak_a !== e.peak) begin
        errors++;
        $error("max_ma: expected %0d, actual %0d", e.peak, peak_a);
      end
      if (trough_a !== e.trough) begin
        errors++;
        $error("min_ma: expected %0d, actual %0d", e.trough, trough_a);
      end
      if (coupled_a !== e.coupled) begin
        errors++;
        $error("is_coupled: expected %0b, actual %0b", e.coupled, coupled_a);
      end
      if (lost_a !== e.lost) begin
        errors++;
        $error("lost_coupling: expected %0b, actual %0b", e.lost, lost_a);
      end
      if (gained_a !== e.gained) begin
        errors++;
        $error("gained_coupling: expected %0b, actual %0b", e.gained, gained_a);
      end
      if (e.gained) gained_seen++;
      if (e.lost) lost_seen++;
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_ma;
  logic                       cfg_wr_en;
  logic [THR_W-1:0]           cfg_wr_data;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_average_ma;
  logic signed [SAMPLE_W-1:0] out_max_ma;
  logic signed [SAMPLE_W-1:0] out_min_ma;
  logic                       out_is_coupled;
  logic                       out_lost_coupling;
  logic                       out_gained_coupling;

  current_monitor_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int thr_settings;

  current_monitor_lwma_coupling dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_ma        (in_sample_ma),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_average_ma      (out_average_ma),
    .out_max_ma          (out_max_ma),
    .out_min_ma          (out_min_ma),
    .out_is_coupled      (out_is_coupled),
    .out_lost_coupling   (out_lost_coupling),
    .out_gained_coupling (out_gained_coupling)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: stall at random, check every accepted transaction
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_reading(out_average_ma, out_max_ma, out_min_ma,
                       out_is_coupled, out_lost_coupling, out_gained_coupling);
    end
  end

  // valid stays high after acceptance until the next item or an idle cycle
  task automatic present_sample(input shortint s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_sample_ma <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_sample(s);
  endtask

  // hold off the sender until every reading is back, then let the sequencer settle
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk);
    repeat (HIST_LEN + 10) @(posedge clk);
  endtask

  task automatic program_threshold(input bit [THR_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.threshold = v;
    thr_settings++;
  endtask

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    shortint s;
    int      v;
    int      thr;
    int      target;
    int      spread;
    in_valid      = 1'b0;
    in_sample_ma  = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    out_stall     = 1'b0;
    rst_n         = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 68;
    thr_settings  = 0;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, a full-scale first sample leaves the minimum alone,
    // averages stay 0 until the ring is full, then gain at the reset threshold
    present_sample(32767);
    present_sample(-32768);
    present_sample(0);
    present_sample(-1);
    present_sample(1);
    repeat (16) present_sample(-32768);
    present_sample(32767);
    wait_for_drain();
    // largest threshold: full-scale negative still couples, this drop loses it
    program_threshold(15'h7fff);
    present_sample(32767);
    present_sample(0);
    present_sample(0);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 19 : (p == 1) ? 68 : 0;
      recv_idle_pct = (p == 0) ? 68 : (p == 1) ? 19 : 0;
      for (int c = 0; c < 5; c++) begin
        wait_for_drain();
        case (c)
          0:       thr = 0;
          1:       thr = 32767;
          default: thr = int'($urandom_range(0, 32767) >> $urandom_range(0, 12));
        endcase
        program_threshold(thr[THR_W-1:0]);
        spread = int'($urandom_range(0, 3000));
        target = thr;
        for (int k = 0; k < 50; k++) begin
          // walk the level across the threshold so the average crosses it
          if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 3))
              0:       target = 0;
              1:       target = -thr;
              default: target = ($urandom_range(0, 1) ? thr : -thr)
                                + int'($urandom_range(0, 400)) - 200;
            endcase
          end
          case ($urandom_range(0, 9))
            0: s = shortint'($urandom);
            1: s = shortint'($urandom_range(0, 1) ? 32767 : -32768);
            default: begin
              v = target + int'($urandom_range(0, 2 * spread)) - spread;
              if (v > 32767) v = 32767;
              if (v < -32768) v = -32768;
              s = shortint'(v);
            end
          endcase
          present_sample(s);
        end
      end
    end

    wait_for_drain();
    $display("summary: %0d readings checked over %0d threshold settings",
             sb.checked, thr_settings);
    $display("summary: %0d coupling gains and %0d losses observed",
             sb.gained_seen, sb.lost_seen);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
